FILE: rtl/core/acpp_pkg.sv
// Shared types and constants for the AC current peak-to-peak meter.
package acpp_pkg;

    localparam int WINDOWS_DEFAULT = 3;

    localparam int SAMPLE_W = 16;
    localparam int SWING_W  = 17;
    localparam int SUM_W    = 18;
    localparam int SCALE_W  = 16;
    localparam int CPW_W    = 6;
    localparam int DC_W     = 7;
    localparam int OUT_W    = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPS_SCALE        = 2'd1;

    localparam logic [CPW_W-1:0]   CPW_RESET   = 6'd4;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd7240;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_ABORT  = 1'b1;

    typedef struct packed {
        logic                       operation;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [OUT_W-1:0] current_milliamps;
        logic             read_ok;
    } t_out;

    // Finished measurement handed from the window tracker to the scaler.
    typedef struct packed {
        logic             ok;
        logic [SUM_W-1:0] sum;
    } t_meas;

endpackage

FILE: rtl/core/acpp_tracker.sv
// Window tracker: min/max, direction changes and the running swing sum.
module acpp_tracker
    import acpp_pkg::*;
#(
    parameter int WINDOWS = WINDOWS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CPW_W-1:0]   i_cycles_per_window,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in                i_in_data,
    output logic               o_meas_valid,
    input  logic               i_meas_ready,
    output t_meas              o_meas
);

    localparam int WD_W = $clog2(WINDOWS + 1);
    localparam logic [WD_W-1:0] WD_LAST = WD_W'(WINDOWS);
    localparam logic [SUM_W:0]  SUM_MAX = {1'b0, {SUM_W{1'b1}}};

    logic signed [SAMPLE_W-1:0] r_prev, n_prev;
    logic                       r_rising, n_rising;
    logic [DC_W-1:0]            r_dc, n_dc;
    logic signed [SAMPLE_W-1:0] r_low, n_low;
    logic signed [SAMPLE_W-1:0] r_high, n_high;
    logic [WD_W-1:0]            r_wd, n_wd;
    logic [SUM_W-1:0]           r_sum, n_sum;
    logic                       r_meas_valid, n_meas_valid;
    t_meas                      r_meas, n_meas;

    logic                       take;
    logic signed [SAMPLE_W-1:0] cur;
    logic                       up;
    logic [DC_W-1:0]            dc_inc;
    logic [DC_W-1:0]            needed;
    logic signed [SWING_W-1:0]  swing_s;
    logic [SUM_W:0]             sum_wide;
    logic [SUM_W-1:0]           sum_sat;
    logic [WD_W-1:0]            wd_inc;
    logic signed [SAMPLE_W-1:0] low_upd, high_upd;
    logic                       rising_upd;

    assign o_in_ready = !r_meas_valid || i_meas_ready;
    assign take       = i_in_valid && o_in_ready;
    assign cur        = i_in_data.sample;
    assign up         = r_prev < cur;

    assign needed = (i_cycles_per_window == '0) ? DC_W'(2) : {i_cycles_per_window, 1'b0};

    always_comb begin
        dc_inc     = r_dc;
        rising_upd = r_rising;
        if (up != r_rising) begin
            dc_inc     = r_dc + DC_W'(1);
            rising_upd = !r_rising;
        end
        low_upd  = r_low;
        high_upd = r_high;
        if (cur < r_low) begin
            low_upd = cur;
        end else if (cur > r_high) begin
            high_upd = cur;
        end
    end

    // High is never negative and low never positive, so the swing fits unsigned.
    assign swing_s  = SWING_W'(high_upd) - SWING_W'(low_upd);
    assign sum_wide = {1'b0, r_sum} + (SUM_W + 1)'(unsigned'(swing_s));
    assign sum_sat  = (sum_wide > SUM_MAX) ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    assign wd_inc   = r_wd + WD_W'(1);

    always_comb begin
        n_prev       = r_prev;
        n_rising     = r_rising;
        n_dc         = r_dc;
        n_low        = r_low;
        n_high       = r_high;
        n_wd         = r_wd;
        n_sum        = r_sum;
        n_meas_valid = r_meas_valid && !i_meas_ready;
        n_meas       = r_meas;
        if (take) begin
            if (i_in_data.operation == OP_ABORT) begin
                n_prev       = '0;
                n_rising     = 1'b1;
                n_dc         = '0;
                n_low        = '0;
                n_high       = '0;
                n_wd         = '0;
                n_sum        = '0;
                n_meas_valid = 1'b1;
                n_meas.ok    = 1'b0;
                n_meas.sum   = '0;
            end else if (dc_inc >= needed) begin
                n_prev   = '0;
                n_rising = 1'b1;
                n_dc     = '0;
                n_low    = '0;
                n_high   = '0;
                if (wd_inc == WD_LAST) begin
                    n_wd         = '0;
                    n_sum        = '0;
                    n_meas_valid = 1'b1;
                    n_meas.ok    = 1'b1;
                    n_meas.sum   = sum_sat;
                end else begin
                    n_wd  = wd_inc;
                    n_sum = sum_sat;
                end
            end else begin
                n_prev   = cur;
                n_rising = rising_upd;
                n_dc     = dc_inc;
                n_low    = low_upd;
                n_high   = high_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= '0;
            r_rising     <= 1'b1;
            r_dc         <= '0;
            r_low        <= '0;
            r_high       <= '0;
            r_wd         <= '0;
            r_sum        <= '0;
            r_meas_valid <= 1'b0;
        end else begin
            r_prev       <= n_prev;
            r_rising     <= n_rising;
            r_dc         <= n_dc;
            r_low        <= n_low;
            r_high       <= n_high;
            r_wd         <= n_wd;
            r_sum        <= n_sum;
            r_meas_valid <= n_meas_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_meas <= n_meas;
    end

    assign o_meas_valid = r_meas_valid;
    assign o_meas       = r_meas;

endmodule

FILE: rtl/core/acpp_scaler.sv
// Scaler: multiplies the swing sum by the Q16 scale into the result register.
module acpp_scaler
    import acpp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [SCALE_W-1:0] i_amps_scale,
    input  logic               i_meas_valid,
    output logic               o_meas_ready,
    input  t_meas              i_meas,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out               o_out_data
);

    logic                       r_valid, n_valid;
    t_out                       r_out, n_out;
    logic [SUM_W+SCALE_W-1:0]   prod;

    assign o_meas_ready = !r_valid || i_out_ready;
    assign prod         = (SUM_W + SCALE_W)'(i_meas.sum) * (SUM_W + SCALE_W)'(i_amps_scale);

    // The product shifted down by 16 always fits the 18-bit result.
    always_comb begin
        n_valid = r_valid && !i_out_ready;
        n_out   = r_out;
        if (i_meas_valid && o_meas_ready) begin
            n_valid                 = 1'b1;
            n_out.current_milliamps = prod[SUM_W+SCALE_W-1:SCALE_W];
            n_out.read_ok           = i_meas.ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/core/ac_current_peak_to_peak_meter.sv
// Top level of the AC current peak-to-peak meter: configuration and the two stages.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one transfer per converter
// sample or abort item. A sample updates the window minimum, maximum and the count
// of direction changes; a window closes once that count reaches twice the cycles
// per window, and after WINDOWS closed windows one result is produced. An abort
// clears all window state and produces a failure result with zero current.
// Output channel (o_out_valid / i_out_ready / o_out_data): one transfer per result.
// A result passes through the window tracker register and then the multiplier
// result register before it reaches the output.
// Throughput: one input transfer per cycle while o_in_ready is high, set by the
// tracker's state update; the scale multiply sits in its own stage after it.
// When the receiver stalls, the output register holds and the tracker register
// behind it still takes one more finished result; after that o_in_ready drops for
// every item, sample or abort, while both registers hold results and i_out_ready
// stays low.
// Reset (synchronous, active low) restores cycles_per_window to 4, amps_scale to
// 7240, clears all window state and empties both stages.
// Configuration writes are taken whenever i_cfg_we is high; index 0 is
// cycles_per_window (low 6 bits), index 1 is amps_scale, other indexes are ignored.
module ac_current_peak_to_peak_meter
    import acpp_pkg::*;
#(
    parameter int WINDOWS = WINDOWS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data
);

    logic [CPW_W-1:0]   r_cpw, n_cpw;
    logic [SCALE_W-1:0] r_scale, n_scale;

    logic  meas_valid;
    logic  meas_ready;
    t_meas meas;

    // Configuration registers; only the low bits of the data are kept.
    always_comb begin
        n_cpw   = r_cpw;
        n_scale = r_scale;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CYCLES_PER_WINDOW: n_cpw   = i_cfg_data[CPW_W-1:0];
                CFG_AMPS_SCALE:        n_scale = i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpw   <= CPW_RESET;
            r_scale <= SCALE_RESET;
        end else begin
            r_cpw   <= n_cpw;
            r_scale <= n_scale;
        end
    end

    // First stage: window tracking and the running sum of swings.
    acpp_tracker #(
        .WINDOWS (WINDOWS)
    ) u_tracker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cycles_per_window (r_cpw),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_in_data           (i_in_data),
        .o_meas_valid        (meas_valid),
        .i_meas_ready        (meas_ready),
        .o_meas              (meas)
    );

    // Second stage: conversion of the summed swing to milliamps.
    acpp_scaler u_scaler (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_amps_scale (r_scale),
        .i_meas_valid (meas_valid),
        .o_meas_ready (meas_ready),
        .i_meas       (meas),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

FILE: tb/acpp_checker.sv
// Checker for the AC current peak-to-peak meter: predicts readings from observed transfers.
module acpp_checker
    import acpp_pkg::*;
#(
    parameter int WINDOWS = WINDOWS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in                   i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out                  i_out_data,
    output int                    o_pending,
    output int                    o_fail_count,
    output int                    o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Q_FRAC      = 16;

    logic [CPW_W-1:0]          cycles_cfg;
    logic [SCALE_W-1:0]        scale_cfg;

    logic signed [SAMPLE_W-1:0] prev_code;
    logic signed [SAMPLE_W-1:0] low_code;
    logic signed [SAMPLE_W-1:0] high_code;
    logic                       climbing;
    logic [DC_W-1:0]            turn_count;
    int                         closed_windows;
    logic [SUM_W-1:0]           swing_sum;

    t_out pending_readings[$];
    int   failures;
    int   results_seen;

    task automatic report_mismatch(input string msg);
        // One line per mismatch, and every one is counted.
        $display("[%0t] mismatch: %s", $time, msg);
        failures++;
    endtask

    task automatic clear_window();
        prev_code  = '0;
        climbing   = 1'b1;
        turn_count = '0;
        low_code   = '0;
        high_code  = '0;
    endtask

    task automatic predict_reading(input t_in item);
        logic signed [SAMPLE_W-1:0] code;
        logic [DC_W-1:0]            needed;
        logic [SWING_W-1:0]         swing;
        logic [SUM_W:0]             sum_wide;
        logic [SUM_W+SCALE_W-1:0]   product;
        int                         diff;
        t_out                       reading;
        if (item.operation == OP_ABORT) begin
            clear_window();
            closed_windows = 0;
            swing_sum      = '0;
            reading.current_milliamps = '0;
            reading.read_ok           = 1'b0;
            pending_readings.push_back(reading);
            return;
        end
        code = item.sample;
        // Equal samples count as not rising.
        if ((prev_code < code) != climbing) begin
            turn_count = turn_count + 1'b1;
            climbing   = !climbing;
        end
        if (code < low_code) begin
            low_code = code;
        end else if (code > high_code) begin
            high_code = code;
        end
        prev_code = code;
        needed = (cycles_cfg == '0) ? DC_W'(2) : {cycles_cfg, 1'b0};
        if (turn_count < needed) return;
        diff     = high_code - low_code;
        swing    = SWING_W'(diff);
        sum_wide = {1'b0, swing_sum} + swing;
        swing_sum = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        clear_window();
        closed_windows++;
        if (closed_windows < WINDOWS) return;
        // The shifted product always fits the 18-bit field, so the cast to it never drops bits.
        product = swing_sum * scale_cfg;
        reading.current_milliamps = OUT_W'(product >> Q_FRAC);
        reading.read_ok           = 1'b1;
        pending_readings.push_back(reading);
        closed_windows = 0;
        swing_sum      = '0;
    endtask

    task automatic check_reading(input t_out got);
        t_out want;
        results_seen++;
        if (pending_readings.size() == 0) begin
            report_mismatch($sformatf("unexpected result milliamps=%0d read_ok=%0b",
                                      got.current_milliamps, got.read_ok));
            return;
        end
        want = pending_readings.pop_front();
        if (got.current_milliamps !== want.current_milliamps)
            report_mismatch($sformatf("current_milliamps %0d, expected %0d",
                                      got.current_milliamps, want.current_milliamps));
        if (got.read_ok !== want.read_ok)
            report_mismatch($sformatf("read_ok %0b, expected %0b", got.read_ok, want.read_ok));
    endtask

    initial begin
        failures     = 0;
        results_seen = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cycles_cfg = CPW_RESET;
            scale_cfg  = SCALE_RESET;
            clear_window();
            closed_windows = 0;
            swing_sum      = '0;
            pending_readings.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CYCLES_PER_WINDOW: cycles_cfg = i_cfg_data[CPW_W-1:0];
                    CFG_AMPS_SCALE:        scale_cfg  = i_cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) check_reading(i_out_data);
            if (i_in_valid && i_in_ready) predict_reading(i_in_data);
        end
        o_pending      <= pending_readings.size();
        o_fail_count   <= failures;
        o_results_seen <= results_seen;
    end

endmodule

FILE: tb/tb.sv
// Testbench top for the AC current peak-to-peak meter: stimulus, receiver, watchdog, verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import acpp_pkg::*;

    localparam int WINDOWS       = WINDOWS_DEFAULT;
    // Both sides idle at random, 13 times in a hundred, unless a steady stretch is running.
    localparam int IDLE_PCT      = 13;
    // Cycles the receiver refuses results during the pressure burst.
    localparam int HOLD_CYCLES   = 300;
    // Two-stage pipeline: an extra wait lets a window in flight settle.
    localparam int SETTLE_CYCLES = 6;
    // Longest correct quiet spell is the hold-off; the limit is several times that.
    localparam int STALL_LIMIT   = 3000;
    localparam int RESULTS_WANTED = 60;
    localparam int ITEM_CAP       = 3000;

    // Indexes that the block does not decode; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in                   i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out                  o_out_data;

    int pending;
    int fail_count;
    int results_seen;

    // Knobs of the random sample generator, set per phase.
    bit steady    = 1'b0;
    bit hold_req  = 1'b0;
    int wave_val  = 0;
    bit wave_up   = 1'b1;
    int wave_run  = 0;
    int wave_span = 40;
    int wave_max_run = 3;
    int abort_pct = 3;

    int items_sent    = 0;
    int aborts_sent   = 0;
    int settings_used = 0;
    int quiet_cycles  = 0;

    ac_current_peak_to_peak_meter #(
        .WINDOWS (WINDOWS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    acpp_checker #(
        .WINDOWS (WINDOWS)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_in_data      (i_in_data),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_data     (o_out_data),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_results_seen (results_seen)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: any transfer or register write shows the run is alive.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver. It takes results at random, except during a steady stretch, and
    // refuses everything for the length of HOLD_CYCLES when the stimulus asks for
    // a hold-off, so that both pipeline registers fill and the input stalls.
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
                @(posedge i_clk);
            end
        end
    end

    function automatic t_in sample_item(input int code);
        t_in item;
        item.operation = OP_SAMPLE;
        item.sample    = SAMPLE_W'(code);
        return item;
    endfunction

    // The sample field of an abort is ignored by the block, so it carries noise.
    function automatic t_in abort_item();
        t_in item;
        item.operation = OP_ABORT;
        item.sample    = SAMPLE_W'($urandom);
        return item;
    endfunction

    // Mostly a zigzag waveform with short runs, so direction changes arrive fast
    // and windows close often. Mixed in are aborts, raw noise and repeated codes.
    function automatic t_in make_item();
        int pick;
        int step;
        pick = $urandom_range(99);
        if (pick < abort_pct) return abort_item();
        if (pick < abort_pct + 10) return sample_item($urandom);
        if (pick < abort_pct + 15) return sample_item(wave_val);
        if (wave_run <= 0) begin
            wave_up  = !wave_up;
            wave_run = $urandom_range(1, wave_max_run);
        end
        wave_run--;
        step = $urandom_range(1, wave_span);
        wave_val = wave_up ? wave_val + step : wave_val - step;
        if (wave_val > 32767) begin
            wave_val = 32767;
            wave_run = 0;
        end else if (wave_val < -32768) begin
            wave_val = -32768;
            wave_run = 0;
        end
        return sample_item(wave_val);
    endfunction

    // One input transfer. Valid is only lowered when an idle cycle is inserted,
    // so back-to-back items keep it high without a same-step toggle.
    task automatic send_item(input t_in item);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (item.operation == OP_ABORT) aborts_sent++;
    endtask

    // Wait until every predicted result has arrived, then let the tracker settle
    // since samples that close no measurement leave nothing to wait for.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers, then the two undecoded indexes with random data.
    task automatic configure(input logic [CFG_DATA_W-1:0] cycles_data,
                             input logic [CFG_DATA_W-1:0] scale_data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CYCLES_PER_WINDOW;
        i_cfg_data  <= cycles_data;
        @(posedge i_clk);
        i_cfg_index <= CFG_AMPS_SCALE;
        i_cfg_data  <= scale_data;
        @(posedge i_clk);
        i_cfg_index <= CFG_SPARE_A;
        i_cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge i_clk);
        i_cfg_index <= CFG_SPARE_B;
        i_cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] cycles_data,
                             input logic [CFG_DATA_W-1:0] scale_data,
                             input int n_items, input int span, input int max_run,
                             input int aborts, input bit no_idle);
        settle();
        configure(cycles_data, scale_data);
        wave_span    = span;
        wave_max_run = max_run;
        abort_pct    = aborts;
        steady       = no_idle;
        repeat (n_items) send_item(make_item());
        steady = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. First the reset register values: the extreme codes set the
        // window minimum and maximum, and an abort reports a failure right away.
        send_item(sample_item(32767));
        send_item(sample_item(-32768));
        send_item(abort_item());

        // One cycle per window and full scale, so a reading needs only six turns.
        settle();
        configure(CFG_DATA_W'(1), 16'hFFFF);
        // Two full-range windows, then a tiny one where a repeated code counts as
        // falling.
        send_item(sample_item(32767));
        send_item(sample_item(-32768));
        send_item(sample_item(32767));
        send_item(sample_item(-32768));
        send_item(sample_item(32767));
        send_item(sample_item(5));
        send_item(sample_item(5));
        send_item(sample_item(6));
        // Back-to-back aborts, and an abort in the middle of a window.
        send_item(abort_item());
        send_item(abort_item());
        send_item(sample_item(-1));
        send_item(sample_item(-1));
        send_item(sample_item(-1));
        send_item(sample_item(0));
        send_item(sample_item(100));
        send_item(abort_item());
        send_item(sample_item(100));
        send_item(sample_item(-100));
        send_item(sample_item(100));
        send_item(sample_item(-100));
        send_item(sample_item(100));

        // Random part. The first setting carries junk in the unused high bits of the
        // cycle count; the second uses a zero cycle count, which acts as one.
        run_phase(16'hFFC1, 16'd0, 200, 40, 3, 3, 1'b0);
        run_phase(16'd0, 16'hFFFF, 200, 30000, 2, 3, 1'b0);
        run_phase(16'd2, CFG_DATA_W'($urandom_range(65535)), 180, 2000, 3, 2, 1'b0);
        // Long windows: no aborts and a turn on nearly every sample, or none would close.
        run_phase(16'd32, 16'd7240, 220, 500, 1, 0, 1'b0);
        run_phase(16'h003F, CFG_DATA_W'($urandom_range(65535)), 300, 20000, 1, 0, 1'b0);
        // A stretch with no idling on either side.
        run_phase(16'd1, CFG_DATA_W'($urandom_range(65535)), 120, 3000, 2, 3, 1'b1);

        // Pressure: the receiver holds off while aborts keep producing results.
        hold_req = 1'b1;
        repeat (40) send_item(($urandom_range(1) == 0) ? abort_item() : make_item());

        // Back to the reset values, and keep going until enough readings came out.
        run_phase(16'd4, 16'd7240, 100, 1000, 3, 2, 1'b0);
        while (results_seen < RESULTS_WANTED && items_sent < ITEM_CAP)
            send_item(make_item());
        settle();

        $display("Covered %0d input transfers (%0d aborts) under %0d register settings.",
                 items_sent, aborts_sent, settings_used);
        $display("Checked %0d results, including a %0d-cycle receiver hold-off.",
                 results_seen, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/acpp_pkg.sv
rtl/core/acpp_tracker.sv
rtl/core/acpp_scaler.sv
rtl/core/ac_current_peak_to_peak_meter.sv
tb/acpp_checker.sv
tb/tb.sv
